// ----- rtl/zgd_pkg.sv -----
// zgd_pkg: shared types and constants of the zone grid disc paint and query block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package zgd_pkg;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned RAD_W      = 31;
  localparam int unsigned WS_W       = 31;
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned LAYER_W    = 3;
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 16;

  // configuration register indexes
  localparam logic REG_GRID_SIDE  = 1'b0;
  localparam logic REG_WORLD_SIZE = 1'b1;

  typedef enum logic [1:0] {
    OP_PAINT = 2'd0,
    OP_TEST  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_z;
    logic [RAD_W-1:0]   radius;
    logic [LAYER_W-1:0] layer;
    logic               any_layer;
    logic               set_bit;
  } item_t;

  // head of the queue between front and back
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic init_busy;
  } stat_t;

  typedef struct packed {
    logic              blocked;
    logic [CELL_W-1:0] cell_value;
    logic              inside_res;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/zgd_mul.sv -----
// zgd_mul: shift-and-add multiplier, one bit of the second operand per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module zgd_mul #(
  parameter int unsigned W = 42
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [W-1:0]   a_i,
  input  wire logic [W-1:0]   b_i,
  output logic                done_o,
  output logic [2*W-1:0]      p_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [2*W-1:0] acc_q, ash_q;
  logic [W-1:0]   bsh_q;
  logic [CW-1:0]  cnt_q;
  logic           run_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      ash_q <= (2*W)'(a_i);
      bsh_q <= b_i;
    end else if (run_q) begin
      if (bsh_q[0]) acc_q <= acc_q + ash_q;
      ash_q <= ash_q << 1;
      bsh_q <= bsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule
`default_nettype wire

// ----- rtl/zgd_div.sv -----
// zgd_div: restoring divider, one quotient bit per cycle, quotient known to fit QB bits
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module zgd_div #(
  parameter int unsigned QB = 9,
  parameter int unsigned DB = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DB+QB-1:0] dividend_i,
  input  wire logic [DB-1:0]    divisor_i,
  output logic                  done_o,
  output logic [QB-1:0]         quot_o
);
  localparam int unsigned LW = DB + QB;
  localparam int unsigned CW = $clog2(QB + 1);

  logic [LW-1:0] rem_q, dsh_q;
  logic [QB-1:0] q_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic          ge;

  assign ge = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(QB);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dsh_q <= LW'(divisor_i) << (QB - 1);
      q_q   <= '0;
    end else if (run_q) begin
      if (ge) rem_q <= rem_q - dsh_q;
      dsh_q <= dsh_q >> 1;
      q_q   <= {q_q[QB-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
endmodule
`default_nettype wire

// ----- rtl/zgd_front.sv -----
// zgd_front: input word acceptance, opcode decode and a two-entry item queue
// depends on zgd_pkg
`timescale 1ns / 1ps
`default_nettype none
module zgd_front import zgd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_valid_i,
  output logic                       s_ready_o,
  input  wire logic [IN_TDATA_W-1:0] s_data_i,
  input  wire logic [1:0]            s_user_i,
  input  wire stat_t                 stat_i,
  output q_head_t                    head_o,
  input  wire logic                  pop_i
);
  item_t      slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  item_t      itm;

  always_comb begin
    itm.op        = op_e'(s_user_i);
    itm.pos_x     = s_data_i[31:0];
    itm.pos_z     = s_data_i[63:32];
    itm.radius    = s_data_i[94:64];
    itm.layer     = s_data_i[97:95];
    itm.any_layer = s_data_i[98];
    itm.set_bit   = s_data_i[99];
  end

  // no intake while the store is swept after reset
  assign s_ready_o = (cnt_q != 2'd2) && !stat_i.init_busy;
  assign push      = s_valid_i && s_ready_o;
  assign pop       = pop_i && (cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= itm;
  end

  assign head_o.valid = cnt_q != 2'd0;
  assign head_o.item  = slot_q[rd_q];
endmodule
`default_nettype wire

// ----- rtl/zgd_back.sv -----
// zgd_back: executes queued items against the cell store: sweep, disc paint, point query
// depends on zgd_pkg, zgd_mul, zgd_div
`timescale 1ns / 1ps
`default_nettype none
module zgd_back import zgd_pkg::*; #(
  parameter int unsigned MAX_SIDE = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire q_head_t                          head_i,
  output logic                                  pop_o,
  input  wire logic [$clog2(MAX_SIDE+1)-1:0]    side_i,
  input  wire logic [WS_W-1:0]                  ws_i,
  input  wire logic                             clr_req_i,
  output stat_t                                 stat_o,
  output logic                                  res_vld_o,
  output res_t                                  res_o,
  input  wire logic                             res_rdy_i
);
  localparam int unsigned SW    = $clog2(MAX_SIDE + 1);
  localparam int unsigned IW    = $clog2(MAX_SIDE);
  localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AB    = $clog2(DEPTH);
  localparam int unsigned LW    = SW + 32;
  localparam int unsigned MW    = SW + 33;
  localparam int unsigned QW    = 2 * MW;
  localparam int unsigned AW    = SW + 34;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_QX   = 4'd2;
  localparam logic [3:0] ST_QXW  = 4'd3;
  localparam logic [3:0] ST_QZ   = 4'd4;
  localparam logic [3:0] ST_QZW  = 4'd5;
  localparam logic [3:0] ST_QAD  = 4'd6;
  localparam logic [3:0] ST_QRD  = 4'd7;
  localparam logic [3:0] ST_QOUT = 4'd8;
  localparam logic [3:0] ST_PM   = 4'd9;
  localparam logic [3:0] ST_PMW  = 4'd10;
  localparam logic [3:0] ST_PSET = 4'd11;
  localparam logic [3:0] ST_PRUN = 4'd12;

  // multiply sequence of the paint setup
  localparam logic [3:0] MS_GWS = 4'd0;
  localparam logic [3:0] MS_GPX = 4'd1;
  localparam logic [3:0] MS_GPZ = 4'd2;
  localparam logic [3:0] MS_GR  = 4'd3;
  localparam logic [3:0] MS_DX  = 4'd4;
  localparam logic [3:0] MS_WAX = 4'd5;
  localparam logic [3:0] MS_DZ  = 4'd6;
  localparam logic [3:0] MS_WAZ = 4'd7;
  localparam logic [3:0] MS_WSQ = 4'd8;
  localparam logic [3:0] MS_LIM = 4'd9;

  function automatic logic axis_in(input logic [POS_W-1:0] p, input logic [WS_W-1:0] ws);
    logic signed [33:0] tp, wse;
    tp  = {p[31], p, 1'b0};
    wse = {3'b000, ws};
    return ((tp + wse) >= 34'sd0) && (tp <= wse);
  endfunction

  function automatic logic [31:0] pos_mag(input logic [POS_W-1:0] p);
    return p[31] ? (32'd0 - p) : p;
  endfunction

  logic [3:0]     state_q, pstep_q;
  logic           clr_pend_q, init_q, wv_q, res_vld_q;
  item_t          item_q;
  logic [AB-1:0]  addr_q, waddr_q;
  logic           win_q;
  logic [SW-1:0]  cx_q, cz_q;
  logic [IW-1:0]  ix_q, iz_q;
  logic [MW-1:0]  gws_q, gpx_q, gpz_q, gr_q;
  logic [QW-1:0]  dx0_q, wax_q, dz0_q, waz_q, wsq_q, lim_q;
  logic [QW-1:0]  ex0_q, k_q, dc_q, ec_q, dz_q, ez_q;
  logic [7:0]     rdata_q;
  res_t           res_q;
  logic [7:0]     mem_q [DEPTH];

  logic [SW-1:0]  g;
  logic [IW-1:0]  gi;
  logic           mul_start, mul_done, div_start, div_done;
  logic [MW-1:0]  mul_a, mul_b;
  logic [QW-1:0]  mul_p;
  logic [SW-1:0]  quot, qclamp;
  logic [POS_W-1:0] qpos;
  logic [31:0]    qu;
  logic [LW-1:0]  num;
  logic [AW-1:0]  ax0, az0, twox, twoz;
  logic [MW-1:0]  max0, maz0;
  logic [QW-1:0]  wax4, waz4, ex0, ez0;
  logic [QW:0]    dsum;
  logic           hit, in_grid, last_col, last_row;
  logic [7:0]     lbit, wdata;
  logic           mem_we, mem_re;
  logic [AB-1:0]  mem_raddr;
  logic [2*SW-1:0] qaddr;
  logic           res_take, res_vld_d, clr_pend_d;

  assign g  = side_i - 1'b1;
  assign gi = IW'(g);

  // query coordinate numerator ((2p + ws) * g + ws), divided by 2 ws
  assign qpos = (state_q == ST_QX) ? item_q.pos_x : item_q.pos_z;
  assign qu   = 32'({qpos, 1'b0} + {1'b0, ws_i});
  assign num  = LW'(qu) * LW'(g) + LW'(ws_i);
  assign div_start = (state_q == ST_QX) || (state_q == ST_QZ);
  assign qclamp = (quot > g) ? g : quot;

  zgd_div #(.QB(SW), .DB(32)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num),
    .divisor_i  ({ws_i, 1'b0}),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // offset of the first cell centre: -g ws - 2 g p
  assign twox = AW'({gpx_q, 1'b0});
  assign twoz = AW'({gpz_q, 1'b0});
  assign ax0  = item_q.pos_x[31] ? (twox - AW'(gws_q)) : (AW'(0) - AW'(gws_q) - twox);
  assign az0  = item_q.pos_z[31] ? (twoz - AW'(gws_q)) : (AW'(0) - AW'(gws_q) - twoz);
  assign max0 = MW'(ax0[AW-1] ? (AW'(0) - ax0) : ax0);
  assign maz0 = MW'(az0[AW-1] ? (AW'(0) - az0) : az0);

  always_comb begin
    mul_a = MW'(g);
    mul_b = MW'(ws_i);
    case (pstep_q)
      MS_GWS: begin mul_a = MW'(g); mul_b = MW'(ws_i); end
      MS_GPX: begin mul_a = MW'(g); mul_b = MW'(pos_mag(item_q.pos_x)); end
      MS_GPZ: begin mul_a = MW'(g); mul_b = MW'(pos_mag(item_q.pos_z)); end
      MS_GR:  begin mul_a = MW'(g); mul_b = MW'(item_q.radius); end
      MS_DX:  begin mul_a = max0; mul_b = max0; end
      MS_WAX: begin mul_a = MW'(ws_i); mul_b = max0; end
      MS_DZ:  begin mul_a = maz0; mul_b = maz0; end
      MS_WAZ: begin mul_a = MW'(ws_i); mul_b = maz0; end
      MS_WSQ: begin mul_a = MW'(ws_i); mul_b = MW'(ws_i); end
      MS_LIM: begin mul_a = {gr_q[MW-2:0], 1'b0}; mul_b = {gr_q[MW-2:0], 1'b0}; end
      default: begin mul_a = MW'(g); mul_b = MW'(ws_i); end
    endcase
  end

  assign mul_start = state_q == ST_PM;

  zgd_mul #(.W(MW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // squares advance by forward differences, all modulo 2^QW
  assign wax4 = wax_q << 2;
  assign waz4 = waz_q << 2;
  assign ex0  = (ax0[AW-1] ? (QW'(0) - wax4) : wax4) + (wsq_q << 2);
  assign ez0  = (az0[AW-1] ? (QW'(0) - waz4) : waz4) + (wsq_q << 2);

  assign dsum     = {1'b0, dc_q} + {1'b0, dz_q};
  assign hit      = dsum <= {1'b0, lim_q};
  assign last_col = ix_q == gi;
  assign last_row = iz_q == gi;

  assign lbit    = 8'd1 << item_q.layer;
  assign wdata   = item_q.set_bit ? (rdata_q | lbit) : (rdata_q & ~lbit);
  assign in_grid = (ws_i != '0) && axis_in(item_q.pos_x, ws_i) && axis_in(item_q.pos_z, ws_i);
  assign qaddr   = cz_q * side_i + (2*SW)'(cx_q);

  assign pop_o = (state_q == ST_IDLE) && !clr_pend_q && head_i.valid;

  // result register takes a new word only once the held one has gone
  assign res_take   = !res_vld_q || res_rdy_i;
  assign res_vld_d  = (res_vld_q && !res_rdy_i) || ((state_q == ST_QOUT) && res_take);
  assign clr_pend_d = clr_req_i || (clr_pend_q && (state_q != ST_IDLE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pstep_q    <= MS_GWS;
      clr_pend_q <= 1'b1;
      init_q     <= 1'b1;
      wv_q       <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      wv_q       <= state_q == ST_PRUN;
      res_vld_q  <= res_vld_d;
      clr_pend_q <= clr_pend_d;
      case (state_q)
        ST_IDLE: begin
          if (clr_pend_q) begin
            state_q <= ST_CLR;
          end else if (head_i.valid) begin
            case (head_i.item.op)
              OP_PAINT: begin
                pstep_q <= MS_GWS;
                state_q <= (ws_i == '0) ? ST_IDLE : ST_PM;
              end
              OP_CLEAR: state_q <= ST_CLR;
              default:  state_q <= ST_QX;
            endcase
          end
        end
        ST_CLR: begin
          if (addr_q == AB'(DEPTH - 1)) begin
            init_q  <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        ST_QX:  state_q <= ST_QXW;
        ST_QXW: if (div_done) state_q <= ST_QZ;
        ST_QZ:  state_q <= ST_QZW;
        ST_QZW: if (div_done) state_q <= ST_QAD;
        ST_QAD: state_q <= ST_QRD;
        ST_QRD: state_q <= ST_QOUT;
        ST_QOUT: if (res_take) state_q <= ST_IDLE;
        ST_PM:  state_q <= ST_PMW;
        ST_PMW: begin
          if (mul_done) begin
            if (pstep_q == MS_LIM) begin
              state_q <= ST_PSET;
            end else begin
              pstep_q <= pstep_q + 1'b1;
              state_q <= ST_PM;
            end
          end
        end
        ST_PSET: state_q <= ST_PRUN;
        ST_PRUN: if (last_col && last_row) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    win_q   <= hit;
    waddr_q <= addr_q;
    if (pop_o) item_q <= head_i.item;
    case (state_q)
      ST_IDLE: addr_q <= '0;
      ST_CLR:  addr_q <= addr_q + 1'b1;
      ST_QXW:  if (div_done) cx_q <= qclamp;
      ST_QZW:  if (div_done) cz_q <= qclamp;
      ST_QAD:  addr_q <= AB'(qaddr);
      ST_QOUT: begin
        if (res_take) begin
          res_q.inside_res <= in_grid;
          res_q.cell_value <= in_grid ? rdata_q : 8'd0;
          res_q.blocked    <= in_grid &&
                              (item_q.any_layer ? (rdata_q != 8'd0) : rdata_q[item_q.layer]);
        end
      end
      ST_PMW: begin
        if (mul_done) begin
          case (pstep_q)
            MS_GWS:  gws_q <= mul_p[MW-1:0];
            MS_GPX:  gpx_q <= mul_p[MW-1:0];
            MS_GPZ:  gpz_q <= mul_p[MW-1:0];
            MS_GR:   gr_q  <= mul_p[MW-1:0];
            MS_DX:   dx0_q <= mul_p;
            MS_WAX:  wax_q <= mul_p;
            MS_DZ:   dz0_q <= mul_p;
            MS_WAZ:  waz_q <= mul_p;
            MS_WSQ:  wsq_q <= mul_p;
            MS_LIM:  lim_q <= mul_p;
            default: gws_q <= gws_q;
          endcase
        end
      end
      ST_PSET: begin
        ex0_q  <= ex0;
        k_q    <= wsq_q << 3;
        dc_q   <= dx0_q;
        ec_q   <= ex0;
        dz_q   <= dz0_q;
        ez_q   <= ez0;
        ix_q   <= '0;
        iz_q   <= '0;
        addr_q <= '0;
      end
      ST_PRUN: begin
        addr_q <= addr_q + 1'b1;
        if (last_col) begin
          ix_q <= '0;
          iz_q <= iz_q + 1'b1;
          dc_q <= dx0_q;
          ec_q <= ex0_q;
          dz_q <= dz_q + ez_q;
          ez_q <= ez_q + k_q;
        end else begin
          ix_q <= ix_q + 1'b1;
          dc_q <= dc_q + ec_q;
          ec_q <= ec_q + k_q;
        end
      end
      default: addr_q <= addr_q;
    endcase
  end

  // cell store: one write and one registered read per cycle
  assign mem_re    = (state_q == ST_PRUN) || (state_q == ST_QRD);
  assign mem_raddr = addr_q;
  assign mem_we    = (state_q == ST_CLR) || (wv_q && win_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      if (state_q == ST_CLR) mem_q[addr_q] <= 8'd0;
      else mem_q[waddr_q] <= wdata;
    end
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  assign stat_o.init_busy = init_q;
  assign res_vld_o        = res_vld_q;
  assign res_o            = res_q;
endmodule
`default_nettype wire

// ----- rtl/zone_grid_disc_paint_query_core.sv -----
// query (opcodes 1, 2): the bit-serial divider runs once per axis, then the cell is read;
//   paint: the serial multiplier setup, then one cell per cycle over the side*side cells;
//   clear: a pass over all MAX_SIDE*MAX_SIDE cells
// reset: a clearing pass over all MAX_SIDE*MAX_SIDE cells (65536 by default) runs first and
//   no word is accepted until it ends; config writes are taken throughout
// a side change also triggers a full clearing pass before the next queued item
`timescale 1ns / 1ps
`default_nettype none
module zone_grid_disc_paint_query_core import zgd_pkg::*; #(
  parameter int unsigned MAX_SIDE = 256
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [WS_W-1:0]        cfg_data_i,
  // input stream
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // pos_x[31:0], pos_z[63:32], radius[94:64], layer[97:95], any_layer[98], set_bit[99]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // opcode[1:0]
  input  wire logic [1:0]             s_axis_tuser_i,
  // result stream
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // blocked[0], cell_value[8:1], inside_res[9]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o
);
  localparam int unsigned SW       = $clog2(MAX_SIDE + 1);
  localparam int unsigned RST_SIDE = (MAX_SIDE < 256) ? MAX_SIDE : 256;

  logic [SW-1:0]   side_q, side_eff;
  logic [WS_W-1:0] ws_q;
  logic            clr_req;
  stat_t           stat;
  q_head_t         head;
  logic            pop;
  logic            res_vld;
  res_t            res;

  // grid side: the low nine bits of the written value, saturated to 2..MAX_SIDE
  always_comb begin
    if (cfg_data_i[8:0] < 9'd2) begin
      side_eff = SW'(2);
    end else if (32'(cfg_data_i[8:0]) > MAX_SIDE) begin
      side_eff = SW'(MAX_SIDE);
    end else begin
      side_eff = SW'(cfg_data_i[8:0]);
    end
  end

  // of the side writes, only a real change of side wipes the store
  assign clr_req = cfg_we_i && (cfg_idx_i == REG_GRID_SIDE) && (side_eff != side_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SW'(RST_SIDE);
      ws_q   <= WS_W'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_SIDE:  side_q <= side_eff;
        REG_WORLD_SIZE: ws_q   <= cfg_data_i;
        default:        ws_q   <= ws_q;
      endcase
    end
  end

  // front: accept and decode words into a short queue
  zgd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_data_i  (s_axis_tdata_i),
    .s_user_i  (s_axis_tuser_i),
    .stat_i    (stat),
    .head_o    (head),
    .pop_i     (pop)
  );

  // back: sweeps, paints and queries against the cell store
  zgd_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .pop_o     (pop),
    .side_i    (side_q),
    .ws_i      (ws_q),
    .clr_req_i (clr_req),
    .stat_o    (stat),
    .res_vld_o (res_vld),
    .res_o     (res),
    .res_rdy_i (m_axis_tready_i)
  );

  assign m_axis_tvalid_o = res_vld;
  assign m_axis_tdata_o  = {6'd0, res.inside_res, res.cell_value, res.blocked};

`ifndef SYNTHESIS
  // no intake during the reset clearing pass
  a_no_accept_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.init_busy |-> !s_axis_tready_o)
    else $error("word accepted during clearing pass");

  // a point outside the grid reports all zero
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[9]) |-> (m_axis_tdata_o[8:0] == 9'd0))
    else $error("outside result carries data");

  // a queued item is never taken during the reset clearing pass
  a_no_pop_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.init_busy |-> !pop)
    else $error("item taken before reset sweep ended");
`endif
endmodule
`default_nettype wire
